>>> design/calclk_pkg.sv
// ----------------------------------------------------------------------------
// calclk_pkg
// Shared types and calendar constants for the calendar clock counter.
// ----------------------------------------------------------------------------
package calclk_pkg;

    localparam logic [5:0] SEC_MAX      = 6'd59;
    localparam logic [5:0] MIN_MAX      = 6'd59;
    localparam logic [5:0] MIN_SYNC     = 6'd58;
    localparam logic [4:0] HOUR_MAX     = 5'd23;
    localparam logic [3:0] MONTH_MAX    = 4'd12;
    localparam logic [3:0] MONTH_FEB    = 4'd2;
    localparam logic [4:0] DAYS_LONG    = 5'd31;
    localparam logic [4:0] DAYS_SHORT   = 5'd30;
    localparam logic [4:0] DAYS_FEB     = 5'd28;
    localparam logic [4:0] DAYS_FEB_LP  = 5'd29;
    // years since 2000 that are centuries not divisible by 400
    localparam logic [7:0] YEAR_C2100   = 8'd100;
    localparam logic [7:0] YEAR_C2200   = 8'd200;

    localparam logic [5:0] RST_SEC      = 6'd45;
    localparam logic [5:0] RST_MIN      = 6'd9;
    localparam logic [4:0] RST_HOUR     = 5'd9;
    localparam logic [4:0] RST_DAY      = 5'd13;
    localparam logic [3:0] RST_MONTH    = 4'd3;
    localparam logic [7:0] RST_YEAR     = 8'd25;
    localparam logic [4:0] RST_SYNC_HR  = 5'd0;
    localparam logic [5:0] RST_INTERVAL = 6'd2;

    // remainder unit: two quotient bits per step over a six-bit minute
    localparam int unsigned DIV_STEPS = 3;
    localparam logic [1:0]  DIV_LAST  = 2'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic step;      // update time, load remainder unit
        logic div_step;  // one remainder iteration
        logic out_load;  // load result register
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_sts;

endpackage

>>> design/calclk_ctrl.sv
// ----------------------------------------------------------------------------
// calclk_ctrl
// Sequencer: accepts an item, runs the remainder unit, loads the result.
// ----------------------------------------------------------------------------
module calclk_ctrl import calclk_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> design/calclk_dp.sv
// ----------------------------------------------------------------------------
// calclk_dp
// Time counters, sync tracking, interval register, remainder unit, result.
// ----------------------------------------------------------------------------
module calclk_dp import calclk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    input  logic       i_advance,
    input  logic       i_cfg_valid,
    input  logic [5:0] i_cfg_data_interval_minutes,
    output logic [5:0] o_second,
    output logic [5:0] o_minute,
    output logic [4:0] o_hour,
    output logic [4:0] o_day,
    output logic [3:0] o_month,
    output logic [7:0] o_year,
    output logic       o_minute_event,
    output logic       o_midnight_event,
    output logic       o_sync_request,
    output logic       o_data_due
);

    function automatic logic [5:0] rem_step(input logic [5:0] rem, input logic b,
                                            input logic [5:0] d);
        logic [6:0] t;
        t = {rem, b};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[5:0];
    endfunction

    logic [5:0] r_sec, n_sec;
    logic [5:0] r_min, n_min;
    logic [4:0] r_hour, n_hour;
    logic [4:0] r_day, n_day;
    logic [3:0] r_month, n_month;
    logic [7:0] r_year, n_year;
    logic [4:0] r_sync_hr, n_sync_hr;
    logic [5:0] r_interval;
    logic       r_min_ev, n_min_ev;
    logic       r_mid_ev, n_mid_ev;
    logic       r_sync_ev, n_sync_ev;
    logic [5:0] r_rem, n_rem;
    logic [5:0] r_dvd;
    logic [1:0] r_cnt;
    logic [4:0] month_len;
    logic       leap;

    assign leap = (r_year[1:0] == 2'b00) && (r_year != YEAR_C2100) && (r_year != YEAR_C2200);

    always_comb begin
        if (r_month == MONTH_FEB) begin
            month_len = leap ? DAYS_FEB_LP : DAYS_FEB;
        end else if (r_month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            month_len = DAYS_SHORT;
        end else begin
            month_len = DAYS_LONG;
        end
    end

    always_comb begin
        n_sec     = r_sec;
        n_min     = r_min;
        n_hour    = r_hour;
        n_day     = r_day;
        n_month   = r_month;
        n_year    = r_year;
        n_sync_hr = r_sync_hr;
        n_min_ev  = 1'b0;
        n_mid_ev  = 1'b0;
        n_sync_ev = 1'b0;
        if (i_advance) begin
            if (r_sec == SEC_MAX) begin
                n_sec    = '0;
                n_min_ev = 1'b1;
                if (r_min == MIN_MAX) begin
                    n_min = '0;
                    if (r_hour == HOUR_MAX) begin
                        n_hour   = '0;
                        n_mid_ev = 1'b1;
                        if (r_day >= month_len) begin
                            n_day = 5'd1;
                            if (r_month == MONTH_MAX) begin
                                n_month = 4'd1;
                                n_year  = r_year + 8'd1;
                            end else begin
                                n_month = r_month + 4'd1;
                            end
                        end else begin
                            n_day = r_day + 5'd1;
                        end
                    end else begin
                        n_hour = r_hour + 5'd1;
                    end
                end else begin
                    n_min = r_min + 6'd1;
                end
            end else begin
                n_sec = r_sec + 6'd1;
            end
            if ((r_sync_hr != n_hour) && (n_min == MIN_SYNC)) begin
                n_sync_ev = 1'b1;
                n_sync_hr = n_hour;
            end
        end
    end

    assign n_rem = rem_step(rem_step(r_rem, r_dvd[5], r_interval), r_dvd[4], r_interval);
    assign o_sts.div_last = (r_cnt == DIV_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec      <= RST_SEC;
            r_min      <= RST_MIN;
            r_hour     <= RST_HOUR;
            r_day      <= RST_DAY;
            r_month    <= RST_MONTH;
            r_year     <= RST_YEAR;
            r_sync_hr  <= RST_SYNC_HR;
            r_interval <= RST_INTERVAL;
        end else begin
            if (i_cmd.step) begin
                r_sec     <= n_sec;
                r_min     <= n_min;
                r_hour    <= n_hour;
                r_day     <= n_day;
                r_month   <= n_month;
                r_year    <= n_year;
                r_sync_hr <= n_sync_hr;
            end
            if (i_cfg_valid) begin
                r_interval <= i_cfg_data_interval_minutes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_min_ev  <= n_min_ev;
            r_mid_ev  <= n_mid_ev;
            r_sync_ev <= n_sync_ev;
            r_rem     <= '0;
            r_dvd     <= n_min;
            r_cnt     <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[3:0], 2'b00};
            r_cnt <= r_cnt + 2'd1;
        end
        if (i_cmd.out_load) begin
            o_second         <= r_sec;
            o_minute         <= r_min;
            o_hour           <= r_hour;
            o_day            <= r_day;
            o_month          <= r_month;
            o_year           <= r_year;
            o_minute_event   <= r_min_ev;
            o_midnight_event <= r_mid_ev;
            o_sync_request   <= r_sync_ev;
            o_data_due       <= (r_interval != '0) && (r_rem == '0);
        end
    end

endmodule

>>> design/calendar_clock_counter_top.sv
// ----------------------------------------------------------------------------
// calendar_clock_counter_top
// Seconds-resolution calendar clock with minute, midnight, sync and data-due
// indications per transfer.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_ready    i_advance
//   out       output     o_out_valid / i_out_ready  time fields and events
//   cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data_interval_minutes
//
// For each item, the accept cycle updates the time, three steps of the
// two-bit-per-step remainder unit compute minute mod interval, and the
// result register is loaded once the out channel can take it.
// A new item is accepted while the previous result waits on the out channel.
// Reset is synchronous; time resets to 09:09:45 on 2025-03-13, interval 2.
// The cfg channel is always ready.
// ----------------------------------------------------------------------------
module calendar_clock_counter_top import calclk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_advance,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [5:0] o_second,
    output logic [5:0] o_minute,
    output logic [4:0] o_hour,
    output logic [4:0] o_day,
    output logic [3:0] o_month,
    output logic [7:0] o_year,
    output logic       o_minute_event,
    output logic       o_midnight_event,
    output logic       o_sync_request,
    output logic       o_data_due,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_data_interval_minutes
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    calclk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    calclk_dp u_dp (
        .i_clk                       (i_clk),
        .i_rst_n                     (i_rst_n),
        .i_cmd                       (cmd),
        .o_sts                       (sts),
        .i_advance                   (i_advance),
        .i_cfg_valid                 (i_cfg_valid),
        .i_cfg_data_interval_minutes (i_cfg_data_interval_minutes),
        .o_second                    (o_second),
        .o_minute                    (o_minute),
        .o_hour                      (o_hour),
        .o_day                       (o_day),
        .o_month                     (o_month),
        .o_year                      (o_year),
        .o_minute_event              (o_minute_event),
        .o_midnight_event            (o_midnight_event),
        .o_sync_request              (o_sync_request),
        .o_data_due                  (o_data_due)
    );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the calendar clock counter against a cycle-free calendar predictor.
// Directed ticks cover report-only items, a minute rollover and the interval
// extremes (zero, one, sixty, above sixty). Random ticks then run under three
// idling mixes, with a fresh random data interval for each mix.
// ----------------------------------------------------------------------------
module testbench;
    import calclk_pkg::*;

    localparam int RANDOM_TICKS   = 1700;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [7:0] year;
        logic       minute_event;
        logic       midnight_event;
        logic       sync_request;
        logic       data_due;
    } t_tick_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic       i_advance = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [5:0] o_second;
    logic [5:0] o_minute;
    logic [4:0] o_hour;
    logic [4:0] o_day;
    logic [3:0] o_month;
    logic [7:0] o_year;
    logic       o_minute_event;
    logic       o_midnight_event;
    logic       o_sync_request;
    logic       o_data_due;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [5:0] i_cfg_data_interval_minutes = 6'd0;

    // calendar predictor state
    logic [5:0] cal_sec;
    logic [5:0] cal_min;
    logic [4:0] cal_hour;
    logic [4:0] cal_day;
    logic [3:0] cal_month;
    logic [7:0] cal_year;
    logic [4:0] cal_synced_hour;
    logic [5:0] cal_interval;

    t_tick_result pending_ticks[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int ticks_sent = 0;
    int results_checked = 0;
    int minute_events_seen = 0;
    int midnight_events_seen = 0;
    int sync_requests_seen = 0;
    int data_due_seen = 0;
    int idle_cycles = 0;

    calendar_clock_counter_top DUT (
        .i_clk                       (i_clk),
        .i_rst_n                     (i_rst_n),
        .i_in_valid                  (i_in_valid),
        .o_in_ready                  (o_in_ready),
        .i_advance                   (i_advance),
        .o_out_valid                 (o_out_valid),
        .i_out_ready                 (i_out_ready),
        .o_second                    (o_second),
        .o_minute                    (o_minute),
        .o_hour                      (o_hour),
        .o_day                       (o_day),
        .o_month                     (o_month),
        .o_year                      (o_year),
        .o_minute_event              (o_minute_event),
        .o_midnight_event            (o_midnight_event),
        .o_sync_request              (o_sync_request),
        .o_data_due                  (o_data_due),
        .i_cfg_valid                 (i_cfg_valid),
        .o_cfg_ready                 (o_cfg_ready),
        .i_cfg_data_interval_minutes (i_cfg_data_interval_minutes)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic bit is_leap_year(input logic [7:0] yr);
        int full;
        full = 2000 + int'(yr);
        return ((full % 4 == 0) && (full % 100 != 0)) || (full % 400 == 0);
    endfunction

    function automatic int days_in_month(input logic [3:0] mon, input logic [7:0] yr);
        if (mon == 4'd2) begin
            return is_leap_year(yr) ? 29 : 28;
        end
        if (mon == 4'd4 || mon == 4'd6 || mon == 4'd9 || mon == 4'd11) begin
            return 30;
        end
        return 31;
    endfunction

    // applies one tick to the predictor state and returns the resulting report
    function automatic t_tick_result predict_tick(input logic adv);
        t_tick_result res;
        int s, m, h, d, mo, y;
        res = '0;
        s  = int'(cal_sec);
        m  = int'(cal_min);
        h  = int'(cal_hour);
        d  = int'(cal_day);
        mo = int'(cal_month);
        y  = int'(cal_year);
        if (adv) begin
            s++;
            if (s > 59) begin
                s = 0;
                res.minute_event = 1'b1;
                m++;
                if (m > 59) begin
                    m = 0;
                    h++;
                    if (h > 23) begin
                        h = 0;
                        res.midnight_event = 1'b1;
                        d++;
                        if (d > days_in_month(4'(mo), 8'(y))) begin
                            d = 1;
                            mo++;
                        end
                        if (mo > 12) begin
                            mo = 1;
                            y = (y + 1) % 256;
                        end
                    end
                end
            end
            if (int'(cal_synced_hour) != h && m == 58) begin
                res.sync_request = 1'b1;
                cal_synced_hour = 5'(h);
            end
        end
        if (cal_interval != 6'd0) begin
            res.data_due = ((m % int'(cal_interval)) == 0);
        end
        cal_sec   = 6'(s);
        cal_min   = 6'(m);
        cal_hour  = 5'(h);
        cal_day   = 5'(d);
        cal_month = 4'(mo);
        cal_year  = 8'(y);
        res.second = cal_sec;
        res.minute = cal_min;
        res.hour   = cal_hour;
        res.day    = cal_day;
        res.month  = cal_month;
        res.year   = cal_year;
        return res;
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    // results are checked before the same edge's input transfer is predicted
    always @(posedge i_clk) begin : scoreboard
        t_tick_result want;
        if (!i_rst_n) begin
            cal_sec         = 6'd45;
            cal_min         = 6'd9;
            cal_hour        = 5'd9;
            cal_day         = 5'd13;
            cal_month       = 4'd3;
            cal_year        = 8'd25;
            cal_synced_hour = 5'd0;
            cal_interval    = 6'd2;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_ticks.size() == 0) begin
                    $error("result transfer with no tick pending");
                    mismatch_count++;
                end else begin
                    want = pending_ticks.pop_front();
                    check_field("second", int'(want.second), int'(o_second));
                    check_field("minute", int'(want.minute), int'(o_minute));
                    check_field("hour", int'(want.hour), int'(o_hour));
                    check_field("day", int'(want.day), int'(o_day));
                    check_field("month", int'(want.month), int'(o_month));
                    check_field("year", int'(want.year), int'(o_year));
                    check_field("minute_event", int'(want.minute_event),
                                int'(o_minute_event));
                    check_field("midnight_event", int'(want.midnight_event),
                                int'(o_midnight_event));
                    check_field("sync_request", int'(want.sync_request),
                                int'(o_sync_request));
                    check_field("data_due", int'(want.data_due), int'(o_data_due));
                    results_checked++;
                    minute_events_seen   += int'(want.minute_event);
                    midnight_events_seen += int'(want.midnight_event);
                    sync_requests_seen   += int'(want.sync_request);
                    data_due_seen        += int'(want.data_due);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cal_interval = i_cfg_data_interval_minutes;
            end
            if (i_in_valid && o_in_ready) begin
                pending_ticks.push_back(predict_tick(i_advance));
                ticks_sent++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // starts and ends at a falling edge; valid stays high for a back-to-back tick
    task automatic send_tick(input logic adv);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_advance  <= adv;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic release_input();
        i_in_valid <= 1'b0;
    endtask

    task automatic write_interval(input logic [5:0] minutes);
        wait (pending_ticks.size() == 0);
        @(negedge i_clk);
        i_cfg_valid                 <= 1'b1;
        i_cfg_data_interval_minutes <= minutes;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_report_only();
        repeat (2) send_tick(1'b0);
        release_input();
    endtask

    task automatic test_minute_rollover();
        repeat (15) send_tick(1'b1);
        send_tick(1'b0);
        release_input();
    endtask

    task automatic test_interval_extremes();
        logic [5:0] settings[4];
        settings = '{6'd0, 6'd63, 6'd60, 6'd1};
        foreach (settings[k]) begin
            write_interval(settings[k]);
            send_tick(1'b0);
            release_input();
        end
    endtask

    task automatic test_random_ticks(input int sender_pct, input int receiver_pct,
                                     input int count);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        write_interval(6'($urandom_range(63)));
        repeat (count) send_tick($urandom_range(99) < 85);
        release_input();
    endtask

    initial begin
        send_idle_pct = 33;
        recv_idle_pct = 85;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_report_only();
        test_minute_rollover();
        test_interval_extremes();
        test_random_ticks(33, 85, RANDOM_TICKS / 3);
        test_random_ticks(85, 33, RANDOM_TICKS / 3);
        test_random_ticks(0, 0, RANDOM_TICKS - 2 * (RANDOM_TICKS / 3));

        wait (pending_ticks.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d ticks, %0d reports checked, ending %0d-%0d-%0d %0d:%0d:%0d",
                 ticks_sent, results_checked, 2000 + cal_year, cal_month, cal_day,
                 cal_hour, cal_min, cal_sec);
        $display("events: %0d minute, %0d midnight, %0d sync, %0d data-due",
                 minute_events_seen, midnight_events_seen, sync_requests_seen,
                 data_due_seen);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
